[sv/chol_pkg.sv]
// Shared widths, types and arithmetic helpers of the 3x3 Cholesky factorizer.
package chol_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	localparam int DIAG_W  = DATA_WIDTH - 1;
	localparam int PROD_W  = 2 * DATA_WIDTH;
	localparam int NUM_W   = (PROD_W > DATA_WIDTH + FRAC_BITS) ? PROD_W : DATA_WIDTH + FRAC_BITS;
	localparam int SQ_BITS = (DATA_WIDTH + FRAC_BITS) / 2;
	localparam int RAD_W   = 2 * SQ_BITS;
	localparam int SQ_REM_W = SQ_BITS + 2;
	localparam int SAT_W   = (SQ_BITS > DIAG_W) ? SQ_BITS : DIAG_W;

	localparam int DIV_LAT  = DATA_WIDTH + 2;
	localparam int SQ_LAT   = SQ_BITS + 2;
	localparam int UNIT_LAT = (DIV_LAT > SQ_LAT) ? DIV_LAT : SQ_LAT;

	localparam int IN_TDATA_W    = ((6 * DATA_WIDTH) + 7) / 8 * 8;
	localparam int OUT_FIELDS_W  = 3 * DIAG_W + 3 * DATA_WIDTH + 2;
	localparam int OUT_TDATA_W   = (OUT_FIELDS_W + 7) / 8 * 8;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [DATA_WIDTH-1:0] mag_t;
	typedef logic [DIAG_W-1:0] diag_t;
	typedef logic [NUM_W-1:0] num_t;

	localparam data_t VMAX = {1'b0, {DIAG_W{1'b1}}};
	localparam data_t VMIN = {1'b1, {DIAG_W{1'b0}}};

	typedef enum logic [1:0] {
		PIV_A00 = 2'd0,
		PIV_P1  = 2'd1,
		PIV_P2  = 2'd2
	} pivot_t;

	typedef struct packed {
		diag_t  u00;
		data_t  u01;
		data_t  u02;
		diag_t  u11;
		data_t  u12;
		diag_t  u22;
		logic   status;
		pivot_t pivot;
	} res_t;

	function automatic data_t sat_sub(input data_t a, input data_t b);
		logic signed [DATA_WIDTH:0] d;
		d = (DATA_WIDTH+1)'(a) - (DATA_WIDTH+1)'(b);
		if (d[DATA_WIDTH] != d[DATA_WIDTH-1]) begin
			return d[DATA_WIDTH] ? VMIN : VMAX;
		end
		return d[DATA_WIDTH-1:0];
	endfunction

	function automatic mag_t mag_of(input data_t x);
		return x[DATA_WIDTH-1] ? mag_t'(-x) : mag_t'(x);
	endfunction

	function automatic logic is_pos(input data_t x);
		return !x[DATA_WIDTH-1] && (x != '0);
	endfunction

	function automatic num_t umul(input mag_t a, input mag_t b);
		logic [PROD_W-1:0] p;
		p = PROD_W'(a) * PROD_W'(b);
		return num_t'(p);
	endfunction

	function automatic num_t frac_num(input mag_t m);
		return num_t'(m) << FRAC_BITS;
	endfunction

endpackage

[sv/chol_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with signed saturation.
module chol_div (
	input  logic           clk,
	input  logic           en,
	input  chol_pkg::num_t num,
	input  chol_pkg::mag_t den,
	input  logic           neg,
	output chol_pkg::data_t quo
);
	import chol_pkg::*;

	localparam int PAD = UNIT_LAT - DIV_LAT;

	logic [NUM_W-DATA_WIDTH-1:0] hi;
	mag_t  rem_s [0:DATA_WIDTH];
	mag_t  low_s [0:DATA_WIDTH];
	mag_t  q_s   [0:DATA_WIDTH];
	mag_t  den_s [0:DATA_WIDTH];
	logic  ovf_s [0:DATA_WIDTH];
	logic  neg_s [0:DATA_WIDTH];
	data_t quo_s [0:PAD];
	mag_t  cap;
	mag_t  qsat;

	assign hi = num[NUM_W-1:DATA_WIDTH];

	// The quotient fits in DATA_WIDTH bits only when the upper numerator half is below den.
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= hi >= (NUM_W-DATA_WIDTH)'(den);
			rem_s[0] <= hi[DATA_WIDTH-1:0];
			low_s[0] <= num[DATA_WIDTH-1:0];
			q_s[0]   <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
		end
	end

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_bit
		logic [DATA_WIDTH:0] cand;
		assign cand = {rem_s[i], low_s[i][DATA_WIDTH-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (cand >= {1'b0, den_s[i]}) begin
					rem_s[i+1] <= DATA_WIDTH'(cand - {1'b0, den_s[i]});
					q_s[i+1]   <= {q_s[i][DATA_WIDTH-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= cand[DATA_WIDTH-1:0];
					q_s[i+1]   <= {q_s[i][DATA_WIDTH-2:0], 1'b0};
				end
				low_s[i+1] <= low_s[i] << 1;
				den_s[i+1] <= den_s[i];
				ovf_s[i+1] <= ovf_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	assign cap  = neg_s[DATA_WIDTH] ? mag_t'(VMIN) : mag_t'(VMAX);
	assign qsat = (ovf_s[DATA_WIDTH] || (q_s[DATA_WIDTH] > cap)) ? cap : q_s[DATA_WIDTH];

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s[0] <= neg_s[DATA_WIDTH] ? data_t'(-qsat) : data_t'(qsat);
		end
	end

	for (genvar k = 1; k <= PAD; k++) begin : g_pad
		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= quo_s[k-1];
			end
		end
	end

	assign quo = quo_s[PAD];

endmodule

[sv/chol_sqrt.sv]
// Pipelined square root of v scaled by the fraction, one root bit per stage.
module chol_sqrt (
	input  logic            clk,
	input  logic            en,
	input  chol_pkg::diag_t v,
	output chol_pkg::diag_t root
);
	import chol_pkg::*;

	localparam int PAD = UNIT_LAT - SQ_LAT;

	logic [RAD_W-1:0]    rad_s  [0:SQ_BITS];
	logic [SQ_REM_W-1:0] rem_s  [0:SQ_BITS];
	logic [SQ_BITS-1:0]  root_s [0:SQ_BITS];
	diag_t               res_s  [0:PAD];
	logic [SAT_W-1:0]    r_ext;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0]  <= RAD_W'(v) << FRAC_BITS;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < SQ_BITS; j++) begin : g_bit
		logic [SQ_REM_W+1:0] cand;
		logic [SQ_REM_W+1:0] trial;
		assign cand  = {rem_s[j], rad_s[j][RAD_W-1 -: 2]};
		assign trial = (SQ_REM_W+2)'({root_s[j], 2'b01});
		always_ff @(posedge clk) begin
			if (en) begin
				if (cand >= trial) begin
					rem_s[j+1]  <= SQ_REM_W'(cand - trial);
					root_s[j+1] <= {root_s[j][SQ_BITS-2:0], 1'b1};
				end else begin
					rem_s[j+1]  <= cand[SQ_REM_W-1:0];
					root_s[j+1] <= {root_s[j][SQ_BITS-2:0], 1'b0};
				end
				rad_s[j+1] <= rad_s[j] << 2;
			end
		end
	end

	assign r_ext = SAT_W'(root_s[SQ_BITS]);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s[0] <= (r_ext > SAT_W'({DIAG_W{1'b1}})) ? '1 : r_ext[DIAG_W-1:0];
		end
	end

	for (genvar k = 1; k <= PAD; k++) begin : g_pad
		always_ff @(posedge clk) begin
			if (en) begin
				res_s[k] <= res_s[k-1];
			end
		end
	end

	assign root = res_s[PAD];

endmodule

[sv/spd_cholesky_factor_3x3.sv]
// Top level of the pipelined 3x3 Cholesky factorizer with stream ports.
// Takes one matrix per cycle while s_axis_tready is high and returns the upper-triangular
// factor U (U^T U = S) in signed Q16.16 (diagonal: unsigned Q15.16). Three chained phases
// of square root and long-division units of UNIT_LAT stages each do the work, with one
// result bit per core stage. A stall on the output holds the whole pipeline after one
// skid entry fills; nothing is lost or repeated. A non-positive pivot gives status 1, the
// index of that pivot and all factor entries zero; in 2x2 mode u02, u12 and u22 are zero.
module spd_cholesky_factor_3x3 (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// a00, a01, a02, a11, a12, a22 from the lowest bit up
	input  logic [chol_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// size_is_three
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// u00, u01, u02, u11, u12, u22, bad_pivot from the lowest bit up
	output logic [chol_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// status
	output logic                             m_axis_tuser
);
	import chol_pkg::*;

	typedef struct packed {
		logic  three;
		logic  pos0;
		data_t a01;
		data_t a02;
		data_t a11;
		data_t a12;
		data_t a22;
	} sb1_t;

	typedef struct packed {
		logic  three;
		logic  pos0;
		logic  p1pos;
		diag_t u00;
		data_t q;
		mag_t  tmag;
		logic  tneg;
	} sb2_t;

	typedef struct packed {
		logic  three;
		logic  pos0;
		logic  p1pos;
		logic  p2pos;
		diag_t u00;
		diag_t u11;
		data_t f1;
		data_t f2;
	} sb3_t;

	logic en;

	// Input capture and products.
	logic  v_s1, three_s1, pos0_s1;
	data_t a00_s1, a01_s1, a02_s1, a11_s1, a12_s1, a22_s1;
	num_t  n11_s1, n21_s1, n22_s1;
	logic  neg21_s1;

	logic  vld1_s [0:UNIT_LAT-1];
	sb1_t  sb1_s  [0:UNIT_LAT-1];
	diag_t u00_w;
	data_t m1_w, m2_w, m3_w;

	// First combine stage.
	logic  v_s2, three_s2, pos0_s2;
	data_t p1_s2, t_s2, q_s2;
	mag_t  mag01_s2, mag02_s2;
	logic  neg01_s2, neg02_s2;
	diag_t u00_s2;

	// Second combine stage.
	logic  v_s3, three_s3, pos0_s3, p1pos_s3;
	data_t p1_s3, q_s3;
	num_t  tt_s3;
	mag_t  tmag_s3, mag01_s3, mag02_s3;
	logic  tneg_s3, neg01_s3, neg02_s3;
	diag_t u00_s3;

	logic  vld2_s [0:UNIT_LAT-1];
	sb2_t  sb2_s  [0:UNIT_LAT-1];
	diag_t u11_w;
	data_t f1_w, f2_w, m4_w;

	// Third combine stage.
	logic  v_s4;
	sb2_t  sb_s4;
	data_t p2_s4, f1_s4, f2_s4;
	diag_t u11_s4;

	logic  vld3_s [0:UNIT_LAT-1];
	sb3_t  sb3_s  [0:UNIT_LAT-1];
	diag_t u22_w;
	data_t u12_w;

	logic  fin_v;
	sb3_t  fin_sb;
	res_t  fin_d;
	logic  bad0, bad1, bad2, cut;

	logic  out_v_q, sk_v_q;
	res_t  out_d_q, sk_d_q;

	assign en = !sk_v_q;
	assign s_axis_tready = en;

	// ---------------- input capture ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			three_s1 <= s_axis_tuser;
			a00_s1   <= s_axis_tdata[0*DATA_WIDTH +: DATA_WIDTH];
			a01_s1   <= s_axis_tdata[1*DATA_WIDTH +: DATA_WIDTH];
			a02_s1   <= s_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH];
			a11_s1   <= s_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH];
			a12_s1   <= s_axis_tdata[4*DATA_WIDTH +: DATA_WIDTH];
			a22_s1   <= s_axis_tdata[5*DATA_WIDTH +: DATA_WIDTH];
			pos0_s1  <= is_pos(s_axis_tdata[0*DATA_WIDTH +: DATA_WIDTH]);
			n11_s1   <= umul(mag_of(s_axis_tdata[1*DATA_WIDTH +: DATA_WIDTH]),
				mag_of(s_axis_tdata[1*DATA_WIDTH +: DATA_WIDTH]));
			n21_s1   <= umul(mag_of(s_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH]),
				mag_of(s_axis_tdata[1*DATA_WIDTH +: DATA_WIDTH]));
			n22_s1   <= umul(mag_of(s_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH]),
				mag_of(s_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH]));
			neg21_s1 <= s_axis_tdata[3*DATA_WIDTH-1] ^ s_axis_tdata[2*DATA_WIDTH-1];
		end
	end

	// ---------------- phase 1: u00 and the a00 quotients ----------------
	chol_sqrt u_sqrt0 (.clk(clk), .en(en), .v(a00_s1[DIAG_W-1:0]), .root(u00_w));
	chol_div u_div_m1 (.clk(clk), .en(en), .num(n11_s1), .den(mag_t'(a00_s1)),
		.neg(1'b0), .quo(m1_w));
	chol_div u_div_m2 (.clk(clk), .en(en), .num(n21_s1), .den(mag_t'(a00_s1)),
		.neg(neg21_s1), .quo(m2_w));
	chol_div u_div_m3 (.clk(clk), .en(en), .num(n22_s1), .den(mag_t'(a00_s1)),
		.neg(1'b0), .quo(m3_w));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < UNIT_LAT; i++) begin
				vld1_s[i] <= 1'b0;
				vld2_s[i] <= 1'b0;
				vld3_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld1_s[0] <= v_s1;
			vld2_s[0] <= v_s3;
			vld3_s[0] <= v_s4;
			for (int i = 1; i < UNIT_LAT; i++) begin
				vld1_s[i] <= vld1_s[i-1];
				vld2_s[i] <= vld2_s[i-1];
				vld3_s[i] <= vld3_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb1_s[0] <= '{three: three_s1, pos0: pos0_s1, a01: a01_s1, a02: a02_s1,
				a11: a11_s1, a12: a12_s1, a22: a22_s1};
			for (int i = 1; i < UNIT_LAT; i++) begin
				sb1_s[i] <= sb1_s[i-1];
			end
		end
	end

	// ---------------- combine: pivot p1, t and the a22 remainder ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= vld1_s[UNIT_LAT-1];
			v_s3 <= v_s2;
			v_s4 <= vld2_s[UNIT_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			three_s2 <= sb1_s[UNIT_LAT-1].three;
			pos0_s2  <= sb1_s[UNIT_LAT-1].pos0;
			p1_s2    <= sat_sub(sb1_s[UNIT_LAT-1].a11, m1_w);
			t_s2     <= sat_sub(sb1_s[UNIT_LAT-1].a12, m2_w);
			q_s2     <= sat_sub(sb1_s[UNIT_LAT-1].a22, m3_w);
			mag01_s2 <= mag_of(sb1_s[UNIT_LAT-1].a01);
			mag02_s2 <= mag_of(sb1_s[UNIT_LAT-1].a02);
			neg01_s2 <= sb1_s[UNIT_LAT-1].a01[DATA_WIDTH-1];
			neg02_s2 <= sb1_s[UNIT_LAT-1].a02[DATA_WIDTH-1];
			u00_s2   <= u00_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			three_s3 <= three_s2;
			pos0_s3  <= pos0_s2;
			p1_s3    <= p1_s2;
			p1pos_s3 <= is_pos(p1_s2);
			q_s3     <= q_s2;
			tt_s3    <= umul(mag_of(t_s2), mag_of(t_s2));
			tmag_s3  <= mag_of(t_s2);
			tneg_s3  <= t_s2[DATA_WIDTH-1];
			mag01_s3 <= mag01_s2;
			mag02_s3 <= mag02_s2;
			neg01_s3 <= neg01_s2;
			neg02_s3 <= neg02_s2;
			u00_s3   <= u00_s2;
		end
	end

	// ---------------- phase 2: u11, u01, u02 and t*t/p1 ----------------
	chol_sqrt u_sqrt1 (.clk(clk), .en(en), .v(p1_s3[DIAG_W-1:0]), .root(u11_w));
	chol_div u_div_f1 (.clk(clk), .en(en), .num(frac_num(mag01_s3)), .den({1'b0, u00_s3}),
		.neg(neg01_s3), .quo(f1_w));
	chol_div u_div_f2 (.clk(clk), .en(en), .num(frac_num(mag02_s3)), .den({1'b0, u00_s3}),
		.neg(neg02_s3), .quo(f2_w));
	chol_div u_div_m4 (.clk(clk), .en(en), .num(tt_s3), .den(mag_t'(p1_s3)),
		.neg(1'b0), .quo(m4_w));

	always_ff @(posedge clk) begin
		if (en) begin
			sb2_s[0] <= '{three: three_s3, pos0: pos0_s3, p1pos: p1pos_s3, u00: u00_s3,
				q: q_s3, tmag: tmag_s3, tneg: tneg_s3};
			for (int i = 1; i < UNIT_LAT; i++) begin
				sb2_s[i] <= sb2_s[i-1];
			end
		end
	end

	// ---------------- combine: pivot p2 ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s4  <= sb2_s[UNIT_LAT-1];
			p2_s4  <= sat_sub(sb2_s[UNIT_LAT-1].q, m4_w);
			f1_s4  <= f1_w;
			f2_s4  <= f2_w;
			u11_s4 <= u11_w;
		end
	end

	// ---------------- phase 3: u22 and u12 ----------------
	chol_sqrt u_sqrt2 (.clk(clk), .en(en), .v(p2_s4[DIAG_W-1:0]), .root(u22_w));
	chol_div u_div_u12 (.clk(clk), .en(en), .num(frac_num(sb_s4.tmag)), .den({1'b0, u11_s4}),
		.neg(sb_s4.tneg), .quo(u12_w));

	always_ff @(posedge clk) begin
		if (en) begin
			sb3_s[0] <= '{three: sb_s4.three, pos0: sb_s4.pos0, p1pos: sb_s4.p1pos,
				p2pos: is_pos(p2_s4), u00: sb_s4.u00, u11: u11_s4, f1: f1_s4, f2: f2_s4};
			for (int i = 1; i < UNIT_LAT; i++) begin
				sb3_s[i] <= sb3_s[i-1];
			end
		end
	end

	// ---------------- result assembly ----------------
	assign fin_v  = vld3_s[UNIT_LAT-1];
	assign fin_sb = sb3_s[UNIT_LAT-1];

	always_comb begin
		bad0 = !fin_sb.pos0;
		bad1 = fin_sb.pos0 && !fin_sb.p1pos;
		bad2 = fin_sb.pos0 && fin_sb.p1pos && fin_sb.three && !fin_sb.p2pos;
		// The third row and column only count in 3x3 mode.
		cut  = bad0 || bad1 || bad2 || !fin_sb.three;
		fin_d.status = bad0 || bad1 || bad2;
		priority if (bad2) begin
			fin_d.pivot = PIV_P2;
		end else if (bad1) begin
			fin_d.pivot = PIV_P1;
		end else begin
			fin_d.pivot = PIV_A00;
		end
		fin_d.u00 = fin_d.status ? '0 : fin_sb.u00;
		fin_d.u01 = fin_d.status ? '0 : fin_sb.f1;
		fin_d.u11 = fin_d.status ? '0 : fin_sb.u11;
		fin_d.u02 = cut ? '0 : fin_sb.f2;
		fin_d.u12 = cut ? '0 : u12_w;
		fin_d.u22 = cut ? '0 : u22_w;
	end

	// Output register and one skid entry; the pipeline stalls only while the skid is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			out_v_q <= sk_v_q || fin_v;
			sk_v_q  <= 1'b0;
		end else if (fin_v && !sk_v_q) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			out_d_q <= sk_v_q ? sk_d_q : fin_d;
		end else if (!sk_v_q) begin
			sk_d_q <= fin_d;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_d_q.status;
	assign m_axis_tdata  = OUT_TDATA_W'({out_d_q.pivot, out_d_q.u22, out_d_q.u12, out_d_q.u11,
		out_d_q.u02, out_d_q.u01, out_d_q.u00});

	// ---------------- assertions ----------------
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid entry holds a result while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(out_v_q && !m_axis_tready && fin_v))
		else $error("skid entry filled without a stalled transfer");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
		(out_d_q.u00 == '0 && out_d_q.u01 == '0 && out_d_q.u02 == '0 &&
		out_d_q.u11 == '0 && out_d_q.u12 == '0 && out_d_q.u22 == '0))
		else $error("error result carries nonzero factor entries");

	a_pivot_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (out_d_q.pivot == PIV_A00))
		else $error("pivot index set on a good result");

endmodule

[test/spd_cholesky_factor_3x3_tb.sv]
// Self-checking testbench of the pipelined 3x3 Cholesky factorizer with stream ports.
module spd_cholesky_factor_3x3_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import chol_pkg::*;

	localparam int LATENCY = 3 * UNIT_LAT + 5;
	localparam int N_RANDOM = 530;
	localparam longint VMAXL = 64'sd2147483647;
	localparam longint VMINL = -64'sd2147483648;
	localparam longint ONE_Q = 64'sd1 << FRAC_BITS;

	typedef struct {
		logic  three;
		data_t a00, a01, a02, a11, a12, a22;
	} matrix_t;

	typedef struct {
		diag_t  u00;
		data_t  u01, u02;
		diag_t  u11;
		data_t  u12;
		diag_t  u22;
		logic   status;
		pivot_t pivot;
	} factor_t;

	typedef struct {
		matrix_t m;
		logic    typed;
		factor_t f;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	factor_t expected_factors[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	logic quiet_tail = 1'b0;
	row_t directed[$];

	spd_cholesky_factor_3x3 uut (.*);

	always #6 clk = ~clk;

	// Unsigned 128-by-64 floor division, capped.
	function automatic logic [63:0] div_cap(input logic [127:0] n, input logic [63:0] d,
			input logic [63:0] cap);
		logic [127:0] q;
		if (d == 0) return cap;
		q = n / d;
		return (q > cap) ? cap : q[63:0];
	endfunction

	function automatic longint root_q(input longint v);
		logic [127:0] n;
		logic [63:0] r, c;
		n = 128'(v) << FRAC_BITS;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (128'(c) * 128'(c) <= n) r = c;
		end
		return (r > 64'(VMAXL)) ? VMAXL : longint'(r);
	endfunction

	function automatic longint abs64(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// trunc(a*b/c) for c > 0, saturated to the data range.
	function automatic longint scaled_quot(input longint a, input longint b, input longint c);
		logic neg;
		logic [63:0] q;
		neg = (a < 0) != (b < 0);
		q = div_cap(128'(abs64(a)) * 128'(abs64(b)), 64'(c),
			neg ? 64'(VMAXL) + 1 : 64'(VMAXL));
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clip(input longint v);
		return (v > VMAXL) ? VMAXL : ((v < VMINL) ? VMINL : v);
	endfunction

	function automatic factor_t factorize(input matrix_t m);
		factor_t f;
		longint a00, a01, a02, a11, a12, a22, d0, d1, d2, o1, o2, o12, p1, p2, t;
		a00 = m.a00; a01 = m.a01; a02 = m.a02; a11 = m.a11; a12 = m.a12; a22 = m.a22;
		f = '{pivot: PIV_A00, default: '0};
		d0 = 0; d1 = 0; d2 = 0; o1 = 0; o2 = 0; o12 = 0;
		if (a00 <= 0) begin
			f.status = 1'b1;
			return f;
		end
		d0 = root_q(a00);
		o1 = scaled_quot(a01, ONE_Q, d0);
		p1 = clip(a11 - scaled_quot(a01, a01, a00));
		if (p1 <= 0) begin
			f.status = 1'b1;
			f.pivot = PIV_P1;
			return f;
		end
		d1 = root_q(p1);
		if (m.three) begin
			o2 = scaled_quot(a02, ONE_Q, d0);
			t = clip(a12 - scaled_quot(a02, a01, a00));
			o12 = scaled_quot(t, ONE_Q, d1);
			p2 = clip(clip(a22 - scaled_quot(a02, a02, a00)) - scaled_quot(t, t, p1));
			if (p2 <= 0) begin
				f.status = 1'b1;
				f.pivot = PIV_P2;
				return f;
			end
			d2 = root_q(p2);
		end
		f.u00 = diag_t'(d0); f.u01 = data_t'(o1); f.u02 = data_t'(o2);
		f.u11 = diag_t'(d1); f.u12 = data_t'(o12); f.u22 = diag_t'(d2);
		return f;
	endfunction

	function automatic data_t rand_entry();
		case ($urandom_range(0, 5))
			0: return data_t'($urandom);
			1: return data_t'($urandom_range(0, 32'h0003_0000));
			2: return -data_t'($urandom_range(0, 32'h0003_0000));
			3: return data_t'($urandom_range(32'h0001_0000, 32'h0100_0000));
			4: return $urandom_range(0, 1) ? VMAX : VMIN;
			default: return data_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly SPD matrices built as U^T U from a random upper factor.
	function automatic matrix_t rand_matrix();
		matrix_t m;
		longint x00, x01, x02, x11, x12, x22;
		int sh;
		m.three = $urandom_range(0, 3) != 0;
		if ($urandom_range(0, 3) == 0) begin
			m.a00 = rand_entry(); m.a01 = rand_entry(); m.a02 = rand_entry();
			m.a11 = rand_entry(); m.a12 = rand_entry(); m.a22 = rand_entry();
			return m;
		end
		sh = $urandom_range(4, 12);
		x00 = $urandom_range(1, 32'hFFFF) >> $urandom_range(0, 15);
		if (x00 == 0) x00 = 1;
		x11 = $urandom_range(0, 32'hFFFF) >> $urandom_range(0, 15);
		x22 = $urandom_range(0, 32'hFFFF) >> $urandom_range(0, 15);
		x01 = longint'($urandom_range(0, 32'hFFFF)) - 32768;
		x02 = longint'($urandom_range(0, 32'hFFFF)) - 32768;
		x12 = longint'($urandom_range(0, 32'hFFFF)) - 32768;
		m.a00 = data_t'(clip((x00 * x00) >>> sh));
		m.a01 = data_t'(clip((x00 * x01) >>> sh));
		m.a02 = data_t'(clip((x00 * x02) >>> sh));
		m.a11 = data_t'(clip((x01 * x01 + x11 * x11) >>> sh));
		m.a12 = data_t'(clip((x01 * x02 + x11 * x12) >>> sh));
		m.a22 = data_t'(clip((x02 * x02 + x12 * x12 + x22 * x22) >>> sh));
		return m;
	endfunction

	function automatic row_t mk(input logic three, input data_t a00, input data_t a01,
			input data_t a02, input data_t a11, input data_t a12, input data_t a22);
		row_t r;
		r.m = '{three, a00, a01, a02, a11, a12, a22};
		r.typed = 1'b0;
		r.f = '{pivot: PIV_A00, default: '0};
		return r;
	endfunction

	function automatic row_t mk_err(input row_t r, input pivot_t p);
		r.typed = 1'b1;
		r.f.status = 1'b1;
		r.f.pivot = p;
		return r;
	endfunction

	task automatic send_matrix(input matrix_t m, input factor_t f);
		if (!quiet_tail && $urandom_range(0, 6) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tdata <= IN_TDATA_W'({m.a22, m.a12, m.a11, m.a02, m.a01, m.a00});
		s_axis_tuser <= m.three;
		s_axis_tvalid <= 1'b1;
		// The ready flop only moves on the rising edge, so its value at the falling
		// edge is the one seen by the next rising edge.
		@(negedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		expected_factors.push_back(f);
	endtask

	task automatic check_field(input string name, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
			errors++;
		end
	endtask

	// Receiver: random stall bursts, and no new burst starts during the tail.
	initial begin
		int stall;
		stall = 0;
		forever begin
			// Outputs are sampled at the falling edge before the rising edge that takes them.
			@(negedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				factor_t e;
				logic [OUT_TDATA_W-1:0] d;
				d = m_axis_tdata;
				if (expected_factors.size() == 0) begin
					$error("result transfer with no matrix outstanding");
					errors++;
				end else begin
					e = expected_factors.pop_front();
					check_field("u00", e.u00, d[0 +: DIAG_W]);
					check_field("u01", $unsigned(e.u01), d[DIAG_W +: DATA_WIDTH]);
					check_field("u02", $unsigned(e.u02), d[DIAG_W+DATA_WIDTH +: DATA_WIDTH]);
					check_field("u11", e.u11, d[DIAG_W+2*DATA_WIDTH +: DIAG_W]);
					check_field("u12", $unsigned(e.u12),
						d[2*DIAG_W+2*DATA_WIDTH +: DATA_WIDTH]);
					check_field("u22", e.u22, d[2*DIAG_W+3*DATA_WIDTH +: DIAG_W]);
					check_field("bad_pivot", e.pivot, d[3*DIAG_W+3*DATA_WIDTH +: 2]);
					check_field("status", e.status, m_axis_tuser);
				end
			end
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 8) == 0) begin
				stall = $urandom_range(1, 18) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		row_t r;
		matrix_t m;
		factor_t f;
		directed.push_back(mk_err(mk(1, '0, 1, 2, 3, 4, 5), PIV_A00));
		directed.push_back(mk_err(mk(1, VMIN, VMAX, VMIN, VMAX, VMIN, VMAX), PIV_A00));
		directed.push_back(mk_err(mk(0, -1, 0, 0, 1, 0, 0), PIV_A00));
		directed.push_back(mk_err(mk(0, 32'h10000, 0, 0, 0, 0, 0), PIV_P1));
		directed.push_back(mk_err(mk(1, 32'h10000, 32'h10000, 0, 32'h10000, 0, 5), PIV_P1));
		directed.push_back(mk_err(mk(1, 32'h10000, 0, 0, 32'h10000, 0, '0), PIV_P2));
		directed.push_back(mk_err(mk(1, 32'h10000, 0, 0, 32'h10000, 0, VMIN), PIV_P2));
		// Identity: unit diagonal, nothing else.
		r = mk(1, 32'h10000, 0, 0, 32'h10000, 0, 32'h10000);
		r.typed = 1'b1;
		r.f.u00 = 31'h10000; r.f.u11 = 31'h10000; r.f.u22 = 31'h10000;
		directed.push_back(r);
		// 2x2 mode ignores the third row entirely, even garbage there.
		r = mk(0, 32'h10000, 0, VMIN, 32'h10000, VMAX, VMIN);
		r.typed = 1'b1;
		r.f.u00 = 31'h10000; r.f.u11 = 31'h10000;
		directed.push_back(r);
		directed.push_back(mk(1, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX));
		directed.push_back(mk(1, VMAX, VMIN, VMIN, VMAX, VMAX, VMAX));
		directed.push_back(mk(1, 1, 0, 0, 1, 0, 1));
		directed.push_back(mk(1, 1, VMAX, VMIN, VMAX, 0, VMAX));
		directed.push_back(mk(0, 1, 1, 0, VMAX, 0, 0));
		directed.push_back(mk(1, 32'h40000, 32'h20000, -32'sh20000, 32'h50000, 0, 32'h90000));
		directed.push_back(mk(1, 32'h10000, 32'h8000, 32'h8000, 32'h10000, 32'h8000, 32'h10000));
		directed.push_back(mk(0, 32'h1, 32'hFFFF, 0, 32'h7FFF_0000, 0, 0));
		directed.push_back(mk(1, 32'hFFFF_FFFF, 0, 0, 1, 0, 1));
		directed.push_back(mk(1, 32'h7FFF_0000, -32'sh7FFF_0000, 32'h1234, VMAX, 32'h55, VMAX));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			f = directed[i].typed ? directed[i].f : factorize(directed[i].m);
			send_matrix(directed[i].m, f);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				// Let the pipeline drain completely once.
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (expected_factors.size() != 0) @(posedge clk);
			end
			if (i == N_RANDOM - 120) quiet_tail = 1'b1;
			m = rand_matrix();
			send_matrix(m, factorize(m));
		end
		s_axis_tvalid <= 1'b0;
		while (expected_factors.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
